// File: rtl/chunk_frustum_sphere_cull_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chunk frustum cull block
// Two wrappers around concurrent assertions, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef CHUNK_FRUSTUM_SPHERE_CULL_ASSERT_SVH
`define CHUNK_FRUSTUM_SPHERE_CULL_ASSERT_SVH

// same-cycle implication
`define CFSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CFSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cfsc_pkg.sv
// ----------------------------------------------------------------------------
// cfsc_pkg
// Shared widths, codes and types of the chunk frustum cull block.
// ----------------------------------------------------------------------------
package cfsc_pkg;

   // default chunk cell size
   localparam int DEF_CELL_WIDTH  = 16;
   localparam int DEF_CELL_HEIGHT = 256;
   localparam int DEF_CELL_DEPTH  = 16;

   // matrix store
   localparam int MAT_DEPTH = 16;
   localparam int MAT_AW    = 4;
   localparam int ENTRY_W   = 32;
   localparam int COORD_W   = 16;

   // shared multiply-accumulate unit
   localparam int OPND_W = ENTRY_W + 1;
   localparam int PROD_W = 2 * OPND_W;
   localparam int ACC_W  = 128;

   // request action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TEST = 1'b1;

   // accumulate shift codes
   localparam logic [1:0] SHIFT_0  = 2'd0;
   localparam logic [1:0] SHIFT_32 = 2'd1;
   localparam logic [1:0] SHIFT_33 = 2'd2;
   localparam logic [1:0] SHIFT_64 = 2'd3;

   typedef struct packed {
      logic       valid;
      logic       clear;
      logic       neg;
      logic [1:0] shift;
   } mac_op_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic visible;
   } seq_status_type;

endpackage

// File: rtl/chunk_frustum_sphere_cull.sv
// ----------------------------------------------------------------------------
// chunk_frustum_sphere_cull
// Bounding-sphere test of a terrain chunk against six view frustum planes.
// ----------------------------------------------------------------------------
// A load transfer (action 0) writes one Q16.16 matrix entry; the block is
// ready again at once. A test transfer (action 1) runs up to six planes
// through a single 33x33 multiplier and 128-bit accumulator: it first fetches
// the fourth matrix column, then per plane forms the coefficients and stops
// there when the plane is degenerate, else sums the length term and doubled
// distance and stops when the centre lies on the inner side, else runs the
// full squared-distance compare. A cull stops the sweep early. The request
// side stays busy for the whole test; a finished result sits in the output
// register so new load or test transfers are taken while it waits.
// ----------------------------------------------------------------------------
module chunk_frustum_sphere_cull #(
   parameter int CELL_WIDTH  = cfsc_pkg::DEF_CELL_WIDTH,
   parameter int CELL_HEIGHT = cfsc_pkg::DEF_CELL_HEIGHT,
   parameter int CELL_DEPTH  = cfsc_pkg::DEF_CELL_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [cfsc_pkg::MAT_AW-1:0]         req_entry_index,
   input  logic signed [cfsc_pkg::ENTRY_W-1:0] req_entry_value,
   input  logic signed [cfsc_pkg::COORD_W-1:0] req_chunk_x,
   input  logic signed [cfsc_pkg::COORD_W-1:0] req_chunk_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_visible
);
   import cfsc_pkg::*;

   logic                    req_xfer;
   logic                    load_we;
   logic                    test_start;
   logic                    result_free;
   logic [MAT_AW-1:0]       rd_addr;
   logic [ENTRY_W-1:0]      rd_data;
   logic signed [ACC_W-1:0] acc;
   mac_op_type              mac_op;
   logic [OPND_W-1:0]       opnd_a, opnd_b;
   seq_status_type          seq_status;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_visible_ff;

   // request side: loads go straight to the matrix, tests start the sequencer
   assign req_ready   = seq_status.idle;
   assign req_xfer    = req_valid && req_ready;
   assign load_we     = req_xfer && (req_action == ACT_LOAD);
   assign test_start  = req_xfer && (req_action == ACT_TEST);

   // output slot is free when empty or being drained this cycle
   assign result_free = !rsp_valid_ff || rsp_ready;

   cfsc_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_we),
      .wr_addr (req_entry_index),
      .wr_data ($unsigned(req_entry_value)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cfsc_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .op     (mac_op),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .acc    (acc)
   );

   cfsc_seq #(
      .CELL_WIDTH  (CELL_WIDTH),
      .CELL_HEIGHT (CELL_HEIGHT),
      .CELL_DEPTH  (CELL_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (test_start),
      .chunk_x     (req_chunk_x),
      .chunk_z     (req_chunk_z),
      .result_free (result_free),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .acc         (acc),
      .mac_op      (mac_op),
      .opnd_a      (opnd_a),
      .opnd_b      (opnd_b),
      .status      (seq_status)
   );

   // result register
   always_comb begin
      if (seq_status.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_status.done) begin
         rsp_visible_ff <= seq_status.visible;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

`include "chunk_frustum_sphere_cull_assert.svh"

   // a test transfer keeps the request side busy on the next cycle
   `CFSC_ASSERT_NEXT(a_test_busy, req_valid && req_ready && (req_action == ACT_TEST), !req_ready, "request taken while a test is running")
   // the shared unit is never issued while idle
   `CFSC_ASSERT_NOW(a_idle_no_issue, req_ready, !mac_op.valid, "multiplier issued while idle")
   // a finished result never overwrites one still waiting
   `CFSC_ASSERT_NOW(a_no_overwrite, rsp_valid && !rsp_ready, !seq_status.done, "pending result overwritten")

endmodule

// File: rtl/cfsc_regfile.sv
// ----------------------------------------------------------------------------
// cfsc_regfile
// View-projection matrix, 16 entries, one write and one read port.
// ----------------------------------------------------------------------------
module cfsc_regfile (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [cfsc_pkg::MAT_AW-1:0]      wr_addr,
   input  logic [cfsc_pkg::ENTRY_W-1:0]     wr_data,
   input  logic [cfsc_pkg::MAT_AW-1:0]      rd_addr,
   output logic [cfsc_pkg::ENTRY_W-1:0]     rd_data
);
   import cfsc_pkg::*;

   logic [ENTRY_W-1:0] mat_ff [MAT_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_DEPTH; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (wr_en) begin
         mat_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = mat_ff[rd_addr];

endmodule

// File: rtl/cfsc_mac.sv
// ----------------------------------------------------------------------------
// cfsc_mac
// Shared 33x33 unsigned multiplier with a shifted signed 128-bit accumulator.
// ----------------------------------------------------------------------------
module cfsc_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  cfsc_pkg::mac_op_type               op,
   input  logic [cfsc_pkg::OPND_W-1:0]        opnd_a,
   input  logic [cfsc_pkg::OPND_W-1:0]        opnd_b,
   output logic signed [cfsc_pkg::ACC_W-1:0]  acc
);
   import cfsc_pkg::*;

   logic [PROD_W-1:0]       prod_ff, prod_in;
   mac_op_type              pend_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0]        term_wide;
   logic [ACC_W-1:0]        term;
   logic signed [ACC_W-1:0] base;

   assign prod_in = PROD_W'(opnd_a) * PROD_W'(opnd_b);

   always_comb begin
      term_wide = ACC_W'(prod_ff);
      case (pend_ff.shift)
         SHIFT_0:  term = term_wide;
         SHIFT_32: term = term_wide << 32;
         SHIFT_33: term = term_wide << 33;
         SHIFT_64: term = term_wide << 64;
         default:  term = term_wide;
      endcase
      base = pend_ff.clear ? '0 : acc_ff;
      if (!pend_ff.valid) begin
         acc_in = acc_ff;
      end else if (pend_ff.neg) begin
         acc_in = base - signed'(term);
      end else begin
         acc_in = base + signed'(term);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= op;
      end
   end

   assign acc = acc_ff;

endmodule

// File: rtl/cfsc_seq.sv
// ----------------------------------------------------------------------------
// cfsc_seq
// Plane sequencer: forms plane coefficients and drives the shared MAC.
// ----------------------------------------------------------------------------
module cfsc_seq #(
   parameter int CELL_WIDTH  = cfsc_pkg::DEF_CELL_WIDTH,
   parameter int CELL_HEIGHT = cfsc_pkg::DEF_CELL_HEIGHT,
   parameter int CELL_DEPTH  = cfsc_pkg::DEF_CELL_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [cfsc_pkg::COORD_W-1:0] chunk_x,
   input  logic signed [cfsc_pkg::COORD_W-1:0] chunk_z,
   input  logic                                result_free,
   output logic [cfsc_pkg::MAT_AW-1:0]         rd_addr,
   input  logic [cfsc_pkg::ENTRY_W-1:0]        rd_data,
   input  logic signed [cfsc_pkg::ACC_W-1:0]   acc,
   output cfsc_pkg::mac_op_type                mac_op,
   output logic [cfsc_pkg::OPND_W-1:0]         opnd_a,
   output logic [cfsc_pkg::OPND_W-1:0]         opnd_b,
   output cfsc_pkg::seq_status_type            status
);
   import cfsc_pkg::*;

   localparam int PX_W   = COORD_W + 1 + $clog2(CELL_WIDTH + 1);
   localparam int PZ_W   = COORD_W + 1 + $clog2(CELL_DEPTH + 1);
   localparam int LEN_W  = PROD_W;
   localparam int TDM_W  = 64;
   localparam int HALF_W = TDM_W / 2;
   localparam int STEP_W = 5;

   localparam logic [OPND_W-1:0] RSQ = OPND_W'(CELL_WIDTH * CELL_WIDTH
      + CELL_HEIGHT * CELL_HEIGHT + CELL_DEPTH * CELL_DEPTH);
   localparam logic [OPND_W-1:0] HEIGHT_OPND = OPND_W'(CELL_HEIGHT);
   localparam logic [OPND_W-1:0] DIST_SCALE  = OPND_W'(2);

   localparam logic [1:0] LAST_COL = 2'd3;
   localparam logic [1:0] LAST_K   = 2'd2;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_BASE   = 2'd1;
   localparam logic [1:0] ST_PLANE  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam logic [STEP_W-1:0] STP_COEF_0    = 5'd0;
   localparam logic [STEP_W-1:0] STP_COEF_1    = 5'd1;
   localparam logic [STEP_W-1:0] STP_COEF_2    = 5'd2;
   localparam logic [STEP_W-1:0] STP_COEF_3    = 5'd3;
   localparam logic [STEP_W-1:0] STP_SQ_A      = 5'd4;
   localparam logic [STEP_W-1:0] STP_SQ_B      = 5'd5;
   localparam logic [STEP_W-1:0] STP_SQ_C      = 5'd6;
   localparam logic [STEP_W-1:0] STP_DIST_A    = 5'd7;
   localparam logic [STEP_W-1:0] STP_DIST_B    = 5'd8;
   localparam logic [STEP_W-1:0] STP_DIST_C    = 5'd9;
   localparam logic [STEP_W-1:0] STP_DIST_D    = 5'd10;
   localparam logic [STEP_W-1:0] STP_DIST_WAIT = 5'd11;
   localparam logic [STEP_W-1:0] STP_DIST_CHK  = 5'd12;
   localparam logic [STEP_W-1:0] STP_TD_LL     = 5'd13;
   localparam logic [STEP_W-1:0] STP_TD_HL     = 5'd14;
   localparam logic [STEP_W-1:0] STP_TD_HH     = 5'd15;
   localparam logic [STEP_W-1:0] STP_RL_LO     = 5'd16;
   localparam logic [STEP_W-1:0] STP_RL_HI     = 5'd17;
   localparam logic [STEP_W-1:0] STP_DIFF_WAIT = 5'd18;
   localparam logic [STEP_W-1:0] STP_DIFF_CHK  = 5'd19;

   function automatic mac_op_type mk_op(logic clr, logic ng, logic [1:0] sh);
      mac_op_type o;
      o.valid = 1'b1;
      o.clear = clr;
      o.neg   = ng;
      o.shift = sh;
      return o;
   endfunction

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        k_ff, k_in;
   logic              minus_ff, minus_in;
   logic              visible_ff, visible_in;

   logic [PX_W-1:0] px_mag_ff, px_mag_in;
   logic [PZ_W-1:0] pz_mag_ff, pz_mag_in;
   logic            px_neg_ff, pz_neg_ff;

   logic [ENTRY_W-1:0] base_ff [4];
   logic [ENTRY_W:0]   coef_mag_ff [4];
   logic               coef_neg_ff [4];
   logic [LEN_W-1:0]   len2_ff, len2_in;
   logic [TDM_W-1:0]   tdm_ff, tdm_in;

   logic                    capture;
   logic                    base_we, coef_we, len2_we, tdm_we;
   logic [1:0]              row_sel;
   logic signed [ENTRY_W:0] base_ext, rd_ext, coef_sum;
   logic [ENTRY_W:0]        coef_abs;
   logic signed [ACC_W-1:0] acc_neg;
   logic                    degenerate, diff_pos, last_plane;
   logic                    plane_done, cull, done;

   // |2c+1| is the ones' complement of c with a low 1 appended
   assign px_mag_in = PX_W'({chunk_x ^ {COORD_W{chunk_x[COORD_W-1]}}, 1'b1})
                      * PX_W'(CELL_WIDTH);
   assign pz_mag_in = PZ_W'({chunk_z ^ {COORD_W{chunk_z[COORD_W-1]}}, 1'b1})
                      * PZ_W'(CELL_DEPTH);

   assign row_sel  = step_ff[1:0];
   assign rd_addr  = (state_ff == ST_BASE) ? {row_sel, LAST_COL} : {row_sel, k_ff};
   assign base_ext = {base_ff[row_sel][ENTRY_W-1], base_ff[row_sel]};
   assign rd_ext   = {rd_data[ENTRY_W-1], rd_data};
   assign coef_sum = minus_ff ? (base_ext - rd_ext) : (base_ext + rd_ext);
   assign coef_abs = coef_sum[ENTRY_W] ? $unsigned(-coef_sum) : $unsigned(coef_sum);

   assign acc_neg    = -acc;
   assign tdm_in     = acc_neg[TDM_W-1:0];
   assign len2_in    = acc[LEN_W-1:0];
   assign degenerate = (coef_mag_ff[0] == '0) && (coef_mag_ff[1] == '0)
                       && (coef_mag_ff[2] == '0);
   assign diff_pos   = !acc[ACC_W-1] && (acc != '0);
   assign last_plane = (k_ff == LAST_K) && minus_ff;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      k_in       = k_ff;
      minus_in   = minus_ff;
      visible_in = visible_ff;
      mac_op     = '0;
      opnd_a     = '0;
      opnd_b     = '0;
      capture    = 1'b0;
      base_we    = 1'b0;
      coef_we    = 1'b0;
      len2_we    = 1'b0;
      tdm_we     = 1'b0;
      plane_done = 1'b0;
      cull       = 1'b0;
      done       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               capture  = 1'b1;
               state_in = ST_BASE;
               step_in  = '0;
               k_in     = '0;
               minus_in = 1'b0;
            end
         end
         ST_BASE: begin
            base_we = 1'b1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STP_COEF_3) begin
               state_in = ST_PLANE;
               step_in  = '0;
            end
         end
         ST_PLANE: begin
            step_in = step_ff + STEP_W'(1);
            unique case (step_ff) inside
               STP_COEF_0, STP_COEF_1, STP_COEF_2, STP_COEF_3: begin
                  coef_we = 1'b1;
               end
               // length term a^2 + b^2 + c^2
               STP_SQ_A: begin
                  if (degenerate) begin
                     plane_done = 1'b1;
                  end else begin
                     mac_op = mk_op(1'b1, 1'b0, SHIFT_0);
                     opnd_a = coef_mag_ff[0];
                     opnd_b = coef_mag_ff[0];
                  end
               end
               STP_SQ_B: begin
                  mac_op = mk_op(1'b0, 1'b0, SHIFT_0);
                  opnd_a = coef_mag_ff[1];
                  opnd_b = coef_mag_ff[1];
               end
               STP_SQ_C: begin
                  mac_op = mk_op(1'b0, 1'b0, SHIFT_0);
                  opnd_a = coef_mag_ff[2];
                  opnd_b = coef_mag_ff[2];
               end
               // doubled distance a*px + b*H + c*pz + 2d
               STP_DIST_A: begin
                  mac_op = mk_op(1'b1, coef_neg_ff[0] ^ px_neg_ff, SHIFT_0);
                  opnd_a = coef_mag_ff[0];
                  opnd_b = OPND_W'(px_mag_ff);
               end
               STP_DIST_B: begin
                  len2_we = 1'b1;
                  mac_op  = mk_op(1'b0, coef_neg_ff[1], SHIFT_0);
                  opnd_a  = coef_mag_ff[1];
                  opnd_b  = HEIGHT_OPND;
               end
               STP_DIST_C: begin
                  mac_op = mk_op(1'b0, coef_neg_ff[2] ^ pz_neg_ff, SHIFT_0);
                  opnd_a = coef_mag_ff[2];
                  opnd_b = OPND_W'(pz_mag_ff);
               end
               STP_DIST_D: begin
                  mac_op = mk_op(1'b0, coef_neg_ff[3], SHIFT_0);
                  opnd_a = coef_mag_ff[3];
                  opnd_b = DIST_SCALE;
               end
               STP_DIST_WAIT: begin
               end
               STP_DIST_CHK: begin
                  if (!acc[ACC_W-1]) begin
                     plane_done = 1'b1;
                  end else begin
                     tdm_we = 1'b1;
                  end
               end
               // dist^2 in three partial products, then minus rsq*len
               STP_TD_LL: begin
                  mac_op = mk_op(1'b1, 1'b0, SHIFT_0);
                  opnd_a = OPND_W'(tdm_ff[HALF_W-1:0]);
                  opnd_b = OPND_W'(tdm_ff[HALF_W-1:0]);
               end
               STP_TD_HL: begin
                  mac_op = mk_op(1'b0, 1'b0, SHIFT_32);
                  opnd_a = OPND_W'(tdm_ff[TDM_W-1:HALF_W]);
                  opnd_b = OPND_W'({tdm_ff[HALF_W-1:0], 1'b0});
               end
               STP_TD_HH: begin
                  mac_op = mk_op(1'b0, 1'b0, SHIFT_64);
                  opnd_a = OPND_W'(tdm_ff[TDM_W-1:HALF_W]);
                  opnd_b = OPND_W'(tdm_ff[TDM_W-1:HALF_W]);
               end
               STP_RL_LO: begin
                  mac_op = mk_op(1'b0, 1'b1, SHIFT_0);
                  opnd_a = len2_ff[OPND_W-1:0];
                  opnd_b = RSQ;
               end
               STP_RL_HI: begin
                  mac_op = mk_op(1'b0, 1'b1, SHIFT_33);
                  opnd_a = len2_ff[LEN_W-1:OPND_W];
                  opnd_b = RSQ;
               end
               STP_DIFF_WAIT: begin
               end
               STP_DIFF_CHK: begin
                  if (diff_pos) begin
                     cull = 1'b1;
                  end else begin
                     plane_done = 1'b1;
                  end
               end
               default: begin
                  plane_done = 1'b1;
               end
            endcase
            if (cull) begin
               visible_in = 1'b0;
               state_in   = ST_FINISH;
            end else if (plane_done) begin
               step_in = '0;
               if (last_plane) begin
                  visible_in = 1'b1;
                  state_in   = ST_FINISH;
               end else begin
                  minus_in = !minus_ff;
                  if (minus_ff) begin
                     k_in = k_ff + 2'd1;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (result_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         k_ff       <= '0;
         minus_ff   <= 1'b0;
         visible_ff <= 1'b1;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         k_ff       <= k_in;
         minus_ff   <= minus_in;
         visible_ff <= visible_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         px_mag_ff <= px_mag_in;
         pz_mag_ff <= pz_mag_in;
         px_neg_ff <= chunk_x[COORD_W-1];
         pz_neg_ff <= chunk_z[COORD_W-1];
      end
      if (base_we) begin
         base_ff[row_sel] <= rd_data;
      end
      if (coef_we) begin
         coef_mag_ff[row_sel] <= coef_abs;
         coef_neg_ff[row_sel] <= coef_sum[ENTRY_W];
      end
      if (len2_we) begin
         len2_ff <= len2_in;
      end
      if (tdm_we) begin
         tdm_ff <= tdm_in;
      end
   end

   assign status = '{idle: (state_ff == ST_IDLE), done: done, visible: visible_ff};

endmodule
